/* hw/rtl/dakf_pkg.sv */
// ----------------------------------------------------------------------------
// Dual angle Kalman filter package
// Shared constants, register indexes and types of the dual angle filter.
// ----------------------------------------------------------------------------
package dakf_pkg;

   // Default widths of the angle and variance datapaths.
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int VAR_WIDTH_DEF   = 20;

   // Configuration register width and reset values (unsigned Q4.16).
   localparam int CFG_WIDTH    = 20;
   localparam int PNOISE_RESET = 65470;
   localparam int MNOISE_RESET = 66;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_NOISE = 1'b1;

   // Request kinds.
   localparam logic KIND_PREDICT = 1'b0;
   localparam logic KIND_UPDATE  = 1'b1;

   // Angle constants in Q4.12 and the Q1.16 gain scale.
   localparam int ANG_PI     = 12868;
   localparam int ANG_TWO_PI = 25736;
   localparam int GAIN_SHIFT = 16;
   localparam int GAIN_ONE   = 65536;

   // Status of the serial divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } dakf_div_stat_type;

endpackage

/* hw/rtl/dakf_if.sv */
// ----------------------------------------------------------------------------
// Dual angle Kalman filter channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface dakf_req_if #(
   parameter int ANGLE_WIDTH = dakf_pkg::ANGLE_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic signed [ANGLE_WIDTH-1:0] yaw_value;
   logic signed [ANGLE_WIDTH-1:0] pitch_value;

   modport source (output valid, kind, yaw_value, pitch_value, input ready);
   modport sink   (input valid, kind, yaw_value, pitch_value, output ready);
endinterface

interface dakf_rsp_if #(
   parameter int ANGLE_WIDTH = dakf_pkg::ANGLE_WIDTH_DEF,
   parameter int VAR_WIDTH   = dakf_pkg::VAR_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] yaw_estimate;
   logic signed [ANGLE_WIDTH-1:0] pitch_estimate;
   logic        [VAR_WIDTH-1:0]   yaw_variance;
   logic        [VAR_WIDTH-1:0]   pitch_variance;

   modport source (output valid, yaw_estimate, pitch_estimate, yaw_variance,
                   pitch_variance, input ready);
   modport sink   (input valid, yaw_estimate, pitch_estimate, yaw_variance,
                   pitch_variance, output ready);
endinterface

/* hw/rtl/dakf_divider.sv */
// ----------------------------------------------------------------------------
// Dual angle Kalman filter serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dakf_divider #(
   parameter int DEN_W = 21,
   parameter int QUO_W = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DEN_W+QUO_W-1:0]        dividend,
   input  logic [DEN_W-1:0]              divisor,
   output logic [QUO_W-1:0]              quotient,
   output dakf_pkg::dakf_div_stat_type   stat
);
   import dakf_pkg::*;

   localparam int REM_W = DEN_W + QUO_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             fits;

   // The shifted divisor fits when it does not exceed the remainder.
   assign fits = (rem_ff >= dsh_ff);

   // One compare and subtract per cycle, the divisor walking right.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rem_in  = dividend;
         dsh_in  = REM_W'(divisor) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   // A start while busy would be dropped.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // A run lasts until the count expires, then reports done once.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a finished run");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && cnt_ff == CNT_W'(QUO_W)))
      else $error("divider failed to begin a run");

endmodule

/* hw/rtl/dual_angle_kalman_filter.sv */
// ----------------------------------------------------------------------------
// Dual angle Kalman filter
// Two scalar Kalman filters (yaw and pitch) on wrapped Q4.12 angles.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  req_bus   in         valid/ready   kind, yaw_value, pitch_value
//  rsp_bus   out        valid/ready   yaw/pitch estimate, yaw/pitch variance
//  csr_*     in         write enable  csr_index, csr_wdata
//
// A predict request goes through S_PRED to S_DONE, which loads its response.
// An update request works on each axis in turn, pitch first: S_PICK, then
// S_DIV (the 17-step serial divider for its gain), then two passes through
// the shared multiplier (S_MULC, S_CORR) for the correction and the variance
// scaling, written back in S_VAR; an axis with a zero denominator skips
// the divider. S_DONE loads the response once the output register is free.
// One request is worked on at a time, so a new request is accepted only after
// the previous one has left S_DONE; a request is accepted while the last
// response still waits in the output register. Reset is synchronous and clears
// the filter state, noise settings and control flags, not the data registers.
// ----------------------------------------------------------------------------
module dual_angle_kalman_filter #(
   parameter int ANGLE_WIDTH = dakf_pkg::ANGLE_WIDTH_DEF,
   parameter int VAR_WIDTH   = dakf_pkg::VAR_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   dakf_req_if.sink                           req_bus,
   dakf_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [dakf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dakf_pkg::CFG_WIDTH-1:0]     csr_wdata
);
   import dakf_pkg::*;

   localparam int EXT_W   = ((ANGLE_WIDTH > 16) ? ANGLE_WIDTH : 16) + 3;
   localparam int SUM_W   = ((VAR_WIDTH > CFG_WIDTH) ? VAR_WIDTH : CFG_WIDTH) + 1;
   localparam int MUL_A_W = (EXT_W > VAR_WIDTH) ? EXT_W : VAR_WIDTH;
   localparam int GAIN_W  = GAIN_SHIFT + 1;
   localparam int PROD_W  = MUL_A_W + GAIN_W;
   localparam int DIVD_W  = SUM_W + GAIN_W;

   localparam logic signed [EXT_W-1:0] PI_X     = EXT_W'(ANG_PI);
   localparam logic signed [EXT_W-1:0] TWO_PI_X = EXT_W'(ANG_TWO_PI);
   localparam logic signed [EXT_W-1:0] ANG_MAX_X =
      {{(EXT_W-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] ANG_MIN_X = ~ANG_MAX_X;
   localparam logic [GAIN_W-1:0] GAIN_ONE_G = GAIN_W'(GAIN_ONE);
   localparam logic [PROD_W-1:0] ROUND_P    = PROD_W'(GAIN_ONE / 2);
   localparam logic [SUM_W-1:0]  VAR_FULL   =
      {{(SUM_W-VAR_WIDTH){1'b0}}, {VAR_WIDTH{1'b1}}};

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PRED = 3'd1;
   localparam logic [2:0] S_PICK = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_MULC = 3'd4;
   localparam logic [2:0] S_CORR = 3'd5;
   localparam logic [2:0] S_VAR  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   // Wrap once into [-pi, pi] and saturate to the angle range.
   function automatic logic signed [ANGLE_WIDTH-1:0] wrap_sat(
      input logic signed [EXT_W-1:0] a);
      logic signed [EXT_W-1:0] b;
      if (a > PI_X) begin
         b = a - TWO_PI_X;
      end else if (a < -PI_X) begin
         b = a + TWO_PI_X;
      end else begin
         b = a;
      end
      if (b > ANG_MAX_X) begin
         b = ANG_MAX_X;
      end else if (b < ANG_MIN_X) begin
         b = ANG_MIN_X;
      end
      return b[ANGLE_WIDTH-1:0];
   endfunction

   function automatic logic [EXT_W-1:0] abs_x(input logic signed [EXT_W-1:0] v);
      return v[EXT_W-1] ? $unsigned(-v) : $unsigned(v);
   endfunction

   // Choose among m, m+-pi and m-2pi (m > 0) or m+2pi (else) the candidate
   // nearest the estimate; the earlier candidate wins a tie.
   function automatic logic signed [EXT_W-1:0] pick_cand(
      input logic signed [ANGLE_WIDTH-1:0] est,
      input logic signed [ANGLE_WIDTH-1:0] meas);
      logic signed [EXT_W-1:0] e, m, c1, c2, c3, best;
      logic        [EXT_W-1:0] bd, d1, d2, d3;
      e = EXT_W'(est);
      m = EXT_W'(meas);
      if (m > 0) begin
         c1 = m - PI_X;
         c2 = m - TWO_PI_X;
         c3 = m + PI_X;
      end else begin
         c1 = m + PI_X;
         c2 = m + TWO_PI_X;
         c3 = m - PI_X;
      end
      d1   = abs_x(c1 - e);
      d2   = abs_x(c2 - e);
      d3   = abs_x(c3 - e);
      best = m;
      bd   = abs_x(m - e);
      if (d1 < bd) begin
         best = c1;
         bd   = d1;
      end
      if (d2 < bd) begin
         best = c2;
         bd   = d2;
      end
      if (d3 < bd) begin
         best = c3;
      end
      return best;
   endfunction

   logic [2:0]                    state_ff, state_in;
   logic                          axis_ff, axis_in;      // 0 pitch, 1 yaw
   logic signed [ANGLE_WIDTH-1:0] yaw_meas_ff, yaw_meas_in;
   logic signed [ANGLE_WIDTH-1:0] pitch_meas_ff, pitch_meas_in;
   logic signed [ANGLE_WIDTH-1:0] yaw_angle_ff, yaw_angle_in;
   logic signed [ANGLE_WIDTH-1:0] pitch_angle_ff, pitch_angle_in;
   logic        [VAR_WIDTH-1:0]   yaw_var_ff, yaw_var_in;
   logic        [VAR_WIDTH-1:0]   pitch_var_ff, pitch_var_in;
   logic        [CFG_WIDTH-1:0]   pnoise_ff, pnoise_in;
   logic        [CFG_WIDTH-1:0]   mnoise_ff, mnoise_in;
   logic signed [EXT_W-1:0]       y_ff, y_in;
   logic        [GAIN_W-1:0]      g_ff, g_in;
   logic        [PROD_W-1:0]      prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_WIDTH-1:0] rsp_yaw_est_ff, rsp_yaw_est_in;
   logic signed [ANGLE_WIDTH-1:0] rsp_pitch_est_ff, rsp_pitch_est_in;
   logic        [VAR_WIDTH-1:0]   rsp_yaw_var_ff, rsp_yaw_var_in;
   logic        [VAR_WIDTH-1:0]   rsp_pitch_var_ff, rsp_pitch_var_in;

   logic signed [ANGLE_WIDTH-1:0] cur_angle, cur_meas, upd_angle;
   logic        [VAR_WIDTH-1:0]   cur_var, new_var;
   logic        [SUM_W-1:0]       sum_s, yaw_pvar, pitch_pvar;
   logic        [DIVD_W-1:0]      div_dividend;
   logic        [GAIN_W-1:0]      div_quotient;
   logic                          div_start;
   dakf_div_stat_type             div_stat;
   logic        [MUL_A_W-1:0]     mul_a;
   logic        [GAIN_W-1:0]      mul_b;
   logic        [PROD_W-1:0]      prod_round, prod_scaled;
   logic signed [EXT_W-1:0]       corr_mag, corr;

   // Operands of the axis being updated.
   assign cur_angle = axis_ff ? yaw_angle_ff : pitch_angle_ff;
   assign cur_meas  = axis_ff ? yaw_meas_ff : pitch_meas_ff;
   assign cur_var   = axis_ff ? yaw_var_ff : pitch_var_ff;

   // Gain division: (var * 2^16 + s / 2) / s with s = var + measure noise.
   assign sum_s        = SUM_W'(cur_var) + SUM_W'(mnoise_ff);
   assign div_dividend = (DIVD_W'(cur_var) << GAIN_SHIFT) + DIVD_W'(sum_s >> 1);

   dakf_divider #(
      .DEN_W (SUM_W),
      .QUO_W (GAIN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (sum_s),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // Shared multiplier: gain times |y| first, then var times (1 - gain).
   always_comb begin
      if (state_ff == S_CORR) begin
         mul_a = MUL_A_W'(cur_var);
         mul_b = GAIN_ONE_G - g_ff;
      end else begin
         mul_a = MUL_A_W'(abs_x(y_ff));
         mul_b = g_ff;
      end
   end
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Round the product half up and drop the gain fraction.
   assign prod_round  = prod_ff + ROUND_P;
   assign prod_scaled = prod_round >> GAIN_SHIFT;
   assign corr_mag    = $signed(prod_scaled[EXT_W-1:0]);
   assign corr        = y_ff[EXT_W-1] ? -corr_mag : corr_mag;
   assign upd_angle   = wrap_sat(EXT_W'(cur_angle) + corr);
   assign new_var     = (prod_scaled > PROD_W'(cur_var)) ? cur_var
                                                         : prod_scaled[VAR_WIDTH-1:0];

   // Predict: variance grows by the process noise and saturates.
   assign yaw_pvar   = SUM_W'(yaw_var_ff) + SUM_W'(pnoise_ff);
   assign pitch_pvar = SUM_W'(pitch_var_ff) + SUM_W'(pnoise_ff);

   // Sequencer and datapath next values.
   always_comb begin
      state_in         = state_ff;
      axis_in          = axis_ff;
      yaw_meas_in      = yaw_meas_ff;
      pitch_meas_in    = pitch_meas_ff;
      yaw_angle_in     = yaw_angle_ff;
      pitch_angle_in   = pitch_angle_ff;
      yaw_var_in       = yaw_var_ff;
      pitch_var_in     = pitch_var_ff;
      pnoise_in        = pnoise_ff;
      mnoise_in        = mnoise_ff;
      y_in             = y_ff;
      g_in             = g_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_yaw_est_in   = rsp_yaw_est_ff;
      rsp_pitch_est_in = rsp_pitch_est_ff;
      rsp_yaw_var_in   = rsp_yaw_var_ff;
      rsp_pitch_var_in = rsp_pitch_var_ff;
      div_start        = 1'b0;

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE: pnoise_in = csr_wdata;
            CSR_MEASURE_NOISE: mnoise_in = csr_wdata;
            default: ;
         endcase
      end

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               yaw_meas_in   = req_bus.yaw_value;
               pitch_meas_in = req_bus.pitch_value;
               axis_in       = 1'b0;
               state_in      = (req_bus.kind == KIND_UPDATE) ? S_PICK : S_PRED;
            end
         end
         S_PRED: begin
            yaw_var_in     = (yaw_pvar > VAR_FULL) ? VAR_FULL[VAR_WIDTH-1:0]
                                                   : yaw_pvar[VAR_WIDTH-1:0];
            pitch_var_in   = (pitch_pvar > VAR_FULL) ? VAR_FULL[VAR_WIDTH-1:0]
                                                     : pitch_pvar[VAR_WIDTH-1:0];
            yaw_angle_in   = wrap_sat(EXT_W'(yaw_angle_ff) + EXT_W'(yaw_meas_ff));
            pitch_angle_in = wrap_sat(EXT_W'(pitch_angle_ff) + EXT_W'(pitch_meas_ff));
            state_in       = S_DONE;
         end
         S_PICK: begin
            y_in = pick_cand(cur_angle, cur_meas) - EXT_W'(cur_angle);
            if (sum_s == '0) begin
               // No variance and no noise: zero gain, nothing to divide.
               g_in     = '0;
               state_in = S_MULC;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               g_in     = (div_quotient > GAIN_ONE_G) ? GAIN_ONE_G : div_quotient;
               state_in = S_MULC;
            end
         end
         S_MULC: begin
            state_in = S_CORR;
         end
         S_CORR: begin
            if (axis_ff) begin
               yaw_angle_in = upd_angle;
            end else begin
               pitch_angle_in = upd_angle;
            end
            state_in = S_VAR;
         end
         S_VAR: begin
            if (axis_ff) begin
               yaw_var_in = new_var;
               state_in   = S_DONE;
            end else begin
               pitch_var_in = new_var;
               axis_in      = 1'b1;
               state_in     = S_PICK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_yaw_est_in   = yaw_angle_ff;
               rsp_pitch_est_in = pitch_angle_ff;
               rsp_yaw_var_in   = yaw_var_ff;
               rsp_pitch_var_in = pitch_var_ff;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         axis_ff        <= 1'b0;
         yaw_angle_ff   <= '0;
         pitch_angle_ff <= '0;
         yaw_var_ff     <= '0;
         pitch_var_ff   <= '0;
         pnoise_ff      <= CFG_WIDTH'(PNOISE_RESET);
         mnoise_ff      <= CFG_WIDTH'(MNOISE_RESET);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         yaw_angle_ff   <= yaw_angle_in;
         pitch_angle_ff <= pitch_angle_in;
         yaw_var_ff     <= yaw_var_in;
         pitch_var_ff   <= pitch_var_in;
         pnoise_ff      <= pnoise_in;
         mnoise_ff      <= mnoise_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      yaw_meas_ff      <= yaw_meas_in;
      pitch_meas_ff    <= pitch_meas_in;
      y_ff             <= y_in;
      g_ff             <= g_in;
      prod_ff          <= prod_in;
      rsp_yaw_est_ff   <= rsp_yaw_est_in;
      rsp_pitch_est_ff <= rsp_pitch_est_in;
      rsp_yaw_var_ff   <= rsp_yaw_var_in;
      rsp_pitch_var_ff <= rsp_pitch_var_in;
   end

   // Channel outputs.
   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.yaw_estimate   = rsp_yaw_est_ff;
   assign rsp_bus.pitch_estimate = rsp_pitch_est_ff;
   assign rsp_bus.yaw_variance   = rsp_yaw_var_ff;
   assign rsp_bus.pitch_variance = rsp_pitch_var_ff;

   // An accepted request keeps the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while the previous one is in work");

   // The gain never exceeds one when the correction is applied.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORR) |-> (g_ff <= GAIN_ONE_G))
      else $error("gain above one");

   // A response appears only when the sequencer finishes a request.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response loaded outside the finish state");

   // The update never increases a variance.
   a_var_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VAR) |=> ($past(axis_ff) ? (yaw_var_ff <= $past(yaw_var_ff))
                                              : (pitch_var_ff <= $past(pitch_var_ff))))
      else $error("update raised a variance");

endmodule
